[rtl/mhpq_pkg.sv]
// Package for the binary min-heap priority queue.
// Holds sizing constants, payload structs and the controller/datapath interface types.
// No dependencies.
`default_nettype none

package mhpq_pkg;

   localparam int CAPACITY       = 1024;
   localparam int TAG_BITS       = 16;
   localparam int KEY_BITS       = 32;
   localparam int REQ_TAG_BITS   = 16;
   localparam int COUNT_OUT_BITS = 11;
   localparam int ADDR_BITS      = $clog2(CAPACITY);
   localparam int COUNT_BITS     = $clog2(CAPACITY + 1);
   localparam int CHILD_BITS     = ADDR_BITS + 1;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic [KEY_BITS-1:0]       key;
      logic [REQ_TAG_BITS-1:0]   tag;
   } req_type;

   typedef struct packed {
      logic                      ok;
      logic [KEY_BITS-1:0]       out_key;
      logic [REQ_TAG_BITS-1:0]   out_tag;
      logic [COUNT_OUT_BITS-1:0] count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic fail;       // report a failed operation
      logic load_ins;   // take new entry, append at tail
      logic rd_parent;  // read parent of hole
      logic up_move;    // parent moves down into hole
      logic rd_rm;      // read root and tail
      logic load_rm;    // capture root, tail becomes moving entry
      logic rd_child;   // read both children of hole
      logic dn_move;    // smaller child moves up into hole
      logic place;      // moving entry lands in hole, report success
   } ctrl_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pos_zero;
      logic up_swap;
      logic dn_stop;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/mhpq_ram.sv]
// Generic simple dual-port RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module mhpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]                      rd_data_a,
   output logic      [WIDTH-1:0]                      rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

[rtl/mhpq_datapath.sv]
// Heap datapath: entry RAM, entry count, hole position, moving entry and result register.
// Depends on mhpq_pkg and mhpq_ram.
`default_nettype none

module mhpq_datapath
   import mhpq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire req_type       req_data,
   input  wire ctrl_cmd_type  cmd,
   output dp_status_type      status,
   output rsp_type            rsp_data,
   output logic               rsp_strobe
);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [ADDR_BITS-1:0]  pos_ff, pos_in;
   entry_type             mov_ff, mov_in;
   entry_type             root_ff, root_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   entry_type             rd_a;
   entry_type             rd_b;
   logic [ADDR_BITS-1:0]  rd_addr_a;
   logic [ADDR_BITS-1:0]  rd_addr_b;
   logic                  wr_en;
   entry_type             wr_data;

   logic [CHILD_BITS-1:0] child_a;
   logic [CHILD_BITS-1:0] child_b;
   logic [CHILD_BITS-1:0] cnt_ext;
   logic                  a_ok;
   logic                  b_ok;
   logic [KEY_BITS-1:0]   best_key;
   logic [CHILD_BITS-1:0] best_pos;
   entry_type             best_entry;

   mhpq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (pos_ff),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // root (position 0) has only child 1
   assign child_a  = {pos_ff, 1'b0};
   assign child_b  = {pos_ff, 1'b1};
   assign cnt_ext  = CHILD_BITS'(count_ff);
   assign a_ok     = (pos_ff != '0) && (child_a < cnt_ext) && (rd_a.key < mov_ff.key);
   assign best_key = a_ok ? rd_a.key : mov_ff.key;
   assign b_ok     = (child_b < cnt_ext) && (rd_b.key < best_key);
   assign best_pos   = b_ok ? child_b : child_a;
   assign best_entry = b_ok ? rd_b : rd_a;

   assign status.full     = (count_ff == COUNT_BITS'(CAPACITY));
   assign status.empty    = (count_ff == '0);
   assign status.pos_zero = (pos_ff == '0);
   assign status.up_swap  = (rd_a.key > mov_ff.key);
   assign status.dn_stop  = !a_ok && !b_ok;

   always_comb begin
      rd_addr_a = pos_ff >> 1;
      rd_addr_b = ADDR_BITS'(child_b);
      if (cmd.rd_rm) begin
         rd_addr_a = '0;
         rd_addr_b = ADDR_BITS'(count_ff - COUNT_BITS'(1));
      end else if (cmd.rd_child) begin
         rd_addr_a = ADDR_BITS'(child_a);
         rd_addr_b = ADDR_BITS'(child_b);
      end
   end

   assign wr_en   = cmd.place | cmd.up_move | cmd.dn_move;
   assign wr_data = cmd.place ? mov_ff : (cmd.up_move ? rd_a : best_entry);

   always_comb begin
      count_in     = count_ff;
      pos_in       = pos_ff;
      mov_in       = mov_ff;
      root_in      = root_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = cmd.fail | cmd.place;
      if (cmd.load_ins) begin
         count_in    = count_ff + COUNT_BITS'(1);
         pos_in      = ADDR_BITS'(count_ff);
         mov_in.key  = req_data.key;
         mov_in.tag  = TAG_BITS'(req_data.tag);
         root_in     = '0;
      end
      if (cmd.load_rm) begin
         count_in = count_ff - COUNT_BITS'(1);
         pos_in   = '0;
         mov_in   = rd_b;
         root_in  = rd_a;
      end
      if (cmd.up_move) begin
         pos_in = pos_ff >> 1;
      end
      if (cmd.dn_move) begin
         pos_in = ADDR_BITS'(best_pos);
      end
      if (cmd.fail) begin
         rsp_in.ok      = 1'b0;
         rsp_in.out_key = '0;
         rsp_in.out_tag = '0;
         rsp_in.count   = COUNT_OUT_BITS'(count_ff);
      end
      if (cmd.place) begin
         rsp_in.ok      = 1'b1;
         rsp_in.out_key = root_ff.key;
         rsp_in.out_tag = REQ_TAG_BITS'(root_ff.tag);
         rsp_in.count   = COUNT_OUT_BITS'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      mov_ff  <= mov_in;
      root_ff <= root_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = rsp_valid_ff;

endmodule

`default_nettype wire

[rtl/mhpq_ctrl.sv]
// Heap controller: sequences insert (sift up) and remove (sift down) operations.
// Depends on mhpq_pkg.
`default_nettype none

module mhpq_ctrl
   import mhpq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          req_kind,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd,
   output logic               busy
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UP_RD  = 3'd1;
   localparam logic [2:0] ST_UP_CMP = 3'd2;
   localparam logic [2:0] ST_RM_LD  = 3'd3;
   localparam logic [2:0] ST_DN_RD  = 3'd4;
   localparam logic [2:0] ST_DN_CMP = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_kind == KIND_INSERT) begin
                  if (status.full) begin
                     cmd.fail = 1'b1;
                  end else begin
                     cmd.load_ins = 1'b1;
                     state_in     = ST_UP_RD;
                  end
               end else begin
                  if (status.empty) begin
                     cmd.fail = 1'b1;
                  end else begin
                     cmd.rd_rm = 1'b1;
                     state_in  = ST_RM_LD;
                  end
               end
            end
         end
         ST_UP_RD: begin
            if (status.pos_zero) begin
               cmd.place = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (status.up_swap) begin
               cmd.up_move = 1'b1;
               state_in    = ST_UP_RD;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_RM_LD: begin
            cmd.load_rm = 1'b1;
            state_in    = ST_DN_RD;
         end
         ST_DN_RD: begin
            cmd.rd_child = 1'b1;
            state_in     = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            if (status.dn_stop) begin
               cmd.place = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd.dn_move = 1'b1;
               state_in    = ST_DN_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

[rtl/min_heap_priority_queue.sv]
// Bounded min-priority queue of (key, tag) entries kept as a binary heap in one RAM.
// busy stays high while an insert sifts up or a remove sifts down; the sift walk reads
// the RAM and compares once per level, and a remove first reads root and tail. A failed
// insert (full) or remove (empty) keeps busy low. Each transfer ends with one rsp_strobe
// cycle, the first cycle with busy low again (for a failed transfer, the cycle after it
// is taken), and the receiver cannot stall it.
// Depends on mhpq_pkg, mhpq_ctrl, mhpq_datapath and mhpq_ram.
`default_nettype none

module min_heap_priority_queue
   import mhpq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output rsp_type      rsp_data,
   output logic         rsp_strobe
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   mhpq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_data.kind),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   mhpq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_data   (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

endmodule

`default_nettype wire

[rtl/mhpq_checker.sv]
// Port-level checker for the heap priority queue, bound to the top level.
// Depends on mhpq_pkg.
`default_nettype none

module mhpq_checker
   import mhpq_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire rsp_type rsp_data,
   input wire logic    rsp_strobe
);

   // every accepted transfer either starts work or reports at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted transfer neither ran nor reported");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.ok) |-> (rsp_data.out_key == '0 && rsp_data.out_tag == '0))
      else $error("failed transfer carries data");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.count <= COUNT_OUT_BITS'(CAPACITY)))
      else $error("count beyond capacity");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

`default_nettype wire

[verif/min_heap_priority_queue_tb.sv]
// Testbench for min_heap_priority_queue: drives insert/remove commands through the
// start/busy handshake and checks every rsp_strobe transfer against a local heap model.
// Depends on mhpq_pkg and the min_heap_priority_queue RTL.

module min_heap_priority_queue_tb;
   import mhpq_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned DRAIN_CYCLES = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   rsp_type rsp_data;
   logic    rsp_strobe;

   logic [KEY_BITS-1:0] heap_keys_mirror [CAPACITY];
   logic [TAG_BITS-1:0] heap_tags_mirror [CAPACITY];
   int unsigned         held_count = 0;
   rsp_type             pq_outcomes [$];
   int unsigned         gap_pct = 0;
   int unsigned         error_count = 0;
   int unsigned         cycle_count;

   min_heap_priority_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_data   (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

   always #4 clock = ~clock;

   function automatic void exchange_entries(input int unsigned a, input int unsigned b);
      logic [KEY_BITS-1:0] k;
      logic [TAG_BITS-1:0] t;
      k = heap_keys_mirror[a];
      t = heap_tags_mirror[a];
      heap_keys_mirror[a] = heap_keys_mirror[b];
      heap_tags_mirror[a] = heap_tags_mirror[b];
      heap_keys_mirror[b] = k;
      heap_tags_mirror[b] = t;
   endfunction

   // Heap update for one command; parent of k is k/2, children 2k and 2k+1.
   function automatic rsp_type pq_step(input req_type op);
      rsp_type     res;
      int unsigned pos, best, left, right;
      bit          settled;
      res = '0;
      if (op.kind == KIND_INSERT) begin
         if (held_count < CAPACITY) begin
            pos = held_count;
            heap_keys_mirror[pos] = op.key;
            heap_tags_mirror[pos] = op.tag[TAG_BITS-1:0];
            held_count++;
            while (pos > 0 && heap_keys_mirror[pos / 2] > heap_keys_mirror[pos]) begin
               exchange_entries(pos, pos / 2);
               pos = pos / 2;
            end
            res.ok = 1'b1;
         end
      end else if (held_count > 0) begin
         res.out_key = heap_keys_mirror[0];
         res.out_tag = heap_tags_mirror[0];
         heap_keys_mirror[0] = heap_keys_mirror[held_count - 1];
         heap_tags_mirror[0] = heap_tags_mirror[held_count - 1];
         held_count--;
         pos = 0;
         settled = 1'b0;
         while (!settled && pos < held_count) begin
            best = pos;
            left = 2 * pos;
            right = left + 1;
            if (left < held_count && heap_keys_mirror[left] < heap_keys_mirror[pos])
               best = left;
            if (right < held_count && heap_keys_mirror[right] < heap_keys_mirror[best])
               best = right;
            if (best == pos) begin
               settled = 1'b1;
            end else begin
               exchange_entries(best, pos);
               pos = best;
            end
         end
         res.ok = 1'b1;
      end
      res.count = COUNT_OUT_BITS'(held_count);
      return res;
   endfunction

   // One command transfer; start stays high unless the sender idles afterwards.
   task automatic send_op(input logic kind, input logic [KEY_BITS-1:0] key,
                          input logic [REQ_TAG_BITS-1:0] tag);
      req_type op;
      op.kind = kind;
      op.key = key;
      op.tag = tag;
      req_data <= op;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pq_outcomes.push_back(pq_step(op));
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      while (pq_outcomes.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pq_outcomes.size() == 0) begin
            $error("unexpected result transfer: %p", rsp_data);
            error_count++;
         end else begin
            want = pq_outcomes.pop_front();
            if (rsp_data.ok !== want.ok) begin
               $error("ok: expected %0d, got %0d", want.ok, rsp_data.ok);
               error_count++;
            end
            if (rsp_data.out_key !== want.out_key) begin
               $error("out_key: expected %h, got %h", want.out_key, rsp_data.out_key);
               error_count++;
            end
            if (rsp_data.out_tag !== want.out_tag) begin
               $error("out_tag: expected %h, got %h", want.out_tag, rsp_data.out_tag);
               error_count++;
            end
            if (rsp_data.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_data.count);
               error_count++;
            end
         end
      end
   end

   task automatic test_empty_remove();
      send_op(KIND_REMOVE, '0, '0);
      send_op(KIND_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
   endtask

   // Extreme keys and tags, and equal keys with different tags checked in the model's heap order.
   task automatic test_extremes_and_ties();
      send_op(KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
      send_op(KIND_INSERT, 32'h0000_0000, 16'h0000);
      send_op(KIND_INSERT, 32'h0001_0000, 16'h1234);
      send_op(KIND_INSERT, 32'h0001_0000, 16'h5678);
      send_op(KIND_INSERT, 32'h0001_0000, 16'h9ABC);
      send_op(KIND_INSERT, 32'h0000_0000, 16'hFFFF);
      send_op(KIND_INSERT, 32'hFFFF_FFFF, 16'h0000);
      repeat (8) send_op(KIND_REMOVE, 32'hA5A5_5A5A, 16'hC3C3);
   endtask

   // Fill to capacity, insert into the full queue, free one slot and refill it.
   task automatic test_full_queue();
      int unsigned fill;
      fill = CAPACITY - held_count;
      repeat (fill) send_op(KIND_INSERT, $urandom_range(300), REQ_TAG_BITS'($urandom()));
      send_op(KIND_INSERT, 32'h0000_0000, 16'hFFFF);
      send_op(KIND_INSERT, 32'hFFFF_FFFF, 16'h0001);
      send_op(KIND_REMOVE, '0, '0);
      send_op(KIND_INSERT, 32'h0000_0001, 16'h8001);
      send_op(KIND_INSERT, 32'h0000_0002, 16'h8002);
   endtask

   // Runs of biased insert/remove mixes so the fill level wanders up and down.
   task automatic test_random_traffic(input int unsigned items);
      int unsigned         sent, run_len, ins_pct, i;
      logic [KEY_BITS-1:0] key;
      sent = 0;
      while (sent < items) begin
         run_len = $urandom_range(120, 30);
         case ($urandom_range(3))
            0: ins_pct = 20;
            1: ins_pct = 50;
            2: ins_pct = 80;
            default: ins_pct = 95;
         endcase
         for (i = 0; i < run_len && sent < items; i++) begin
            case ($urandom_range(3))
               0: key = $urandom();
               1: key = $urandom_range(15);
               2: key = 32'hFFFF_FFFF - $urandom_range(7);
               default: key = {16'($urandom()), 16'h0000};
            endcase
            send_op(($urandom_range(99) < ins_pct) ? KIND_INSERT : KIND_REMOVE, key,
                    REQ_TAG_BITS'($urandom()));
            sent++;
         end
      end
   endtask

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      gap_pct = 27;
      test_empty_remove();
      test_extremes_and_ties();
      test_random_traffic(200);
      wait_all_results();
      gap_pct = 74;
      test_full_queue();
      test_random_traffic(200);
      wait_all_results();
      gap_pct = 0;
      test_random_traffic(200);
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/mhpq_datapath.sv
rtl/mhpq_ctrl.sv
rtl/min_heap_priority_queue.sv
rtl/mhpq_checker.sv
verif/min_heap_priority_queue_tb.sv
